### rtl/core/ssc_pkg.sv
// ----------------------------------------------------------------------------
// ssc_pkg: shared definitions for the segment stabbing counter
// Sizes, operation codes, controller states and the command and status
// groups passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package ssc_pkg;

    // Store depth and coordinate width.
    localparam int MAX_SEGMENTS  = 1024;
    localparam int COORD_WIDTH   = 32;

    // Fixed port field widths.
    localparam int FIELD_W       = 32;
    localparam int OP_W          = 2;
    localparam int COUNT_FIELD_W = 11;

    // Derived widths: store index and segment count (count can reach the depth).
    localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

    // Operation codes.
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic exec;
        logic scan;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic op_query;
        logic store_empty;
        logic scan_last;
    } t_status;

    // Turns a two's complement coordinate into an offset-binary key, so that
    // an unsigned compare gives the signed order.
    function automatic logic [COORD_WIDTH-1:0] coord_key(input logic [FIELD_W-1:0] raw);
        logic [COORD_WIDTH-1:0] sign_bit;
        sign_bit = {1'b1, {(COORD_WIDTH-1){1'b0}}};
        return raw[COORD_WIDTH-1:0] ^ sign_bit;
    endfunction

endpackage

### rtl/core/ssc_ctrl.sv
// ----------------------------------------------------------------------------
// ssc_ctrl: sequencing controller
// Steps each item through execute and, for a query on a non-empty store, scan
// and drain, and raises the result strobe for one cycle at the end.
// ----------------------------------------------------------------------------
module ssc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  ssc_pkg::t_status i_status,
    output ssc_pkg::t_cmd    o_cmd,
    output logic             o_busy,
    output logic             o_strobe
);
    import ssc_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_status.op_query && !i_status.store_empty) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SCAN: begin
                if (i_status.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs decoded from the state.
    always_comb begin
        o_cmd.accept = 1'b0;
        o_cmd.exec   = 1'b0;
        o_cmd.scan   = 1'b0;
        o_busy       = 1'b1;
        o_strobe     = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_busy       = 1'b0;
                o_cmd.accept = i_start;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
            end
            S_DRAIN: begin
                o_busy = 1'b1;
            end
            S_DONE: begin
                o_strobe = 1'b1;
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

endmodule

### rtl/core/ssc_datapath.sv
// ----------------------------------------------------------------------------
// ssc_datapath: segment store and counting datapath
// Holds the segment memory and count, orders load endpoints, and walks the
// store one entry a cycle to count segments that contain the query point.
// ----------------------------------------------------------------------------
module ssc_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ssc_pkg::t_cmd                       i_cmd,
    input  logic [ssc_pkg::OP_W-1:0]            i_op,
    input  logic [ssc_pkg::FIELD_W-1:0]         i_first_end,
    input  logic [ssc_pkg::FIELD_W-1:0]         i_second_end,
    output ssc_pkg::t_status                    o_status,
    output logic [ssc_pkg::COUNT_FIELD_W-1:0]   o_covering_count,
    output logic                                o_store_full
);
    import ssc_pkg::*;

    // Segment memory: each word holds {low, high} as offset-binary keys.
    logic [2*COORD_WIDTH-1:0] r_mem [MAX_SEGMENTS];

    // Latched item.
    logic [OP_W-1:0]          r_op;
    logic [COORD_WIDTH-1:0]   r_key_a;
    logic [COORD_WIDTH-1:0]   r_key_b;

    // Control state.
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic [IDX_W-1:0]         r_idx;
    logic [IDX_W-1:0]         n_idx;
    logic                     r_rd_vld;
    logic [CNT_W-1:0]         r_acc;
    logic [CNT_W-1:0]         n_acc;
    logic                     r_full;
    logic                     n_full;

    // Memory read data and decoded helpers.
    logic [2*COORD_WIDTH-1:0] r_rd_data;
    logic [COORD_WIDTH-1:0]   w_low;
    logic [COORD_WIDTH-1:0]   w_high;
    logic [COORD_WIDTH-1:0]   w_rd_low;
    logic [COORD_WIDTH-1:0]   w_rd_high;
    logic                     w_store_full;
    logic                     w_write;
    logic                     w_hit;

    // Order the endpoints of a load.
    assign w_low  = (r_key_a < r_key_b) ? r_key_a : r_key_b;
    assign w_high = (r_key_a < r_key_b) ? r_key_b : r_key_a;

    assign w_store_full = (r_count == CNT_W'(MAX_SEGMENTS));
    assign w_write      = i_cmd.exec && (r_op == OP_LOAD) && !w_store_full;

    // Containment test on the entry read in the previous cycle.
    assign w_rd_low  = r_rd_data[2*COORD_WIDTH-1:COORD_WIDTH];
    assign w_rd_high = r_rd_data[COORD_WIDTH-1:0];
    assign w_hit     = (w_rd_low <= r_key_a) && (r_key_a <= w_rd_high);

    // Status towards the controller.
    assign o_status.op_query    = (r_op == OP_QUERY);
    assign o_status.store_empty = (r_count == '0);
    assign o_status.scan_last   = (CNT_W'(r_idx) == (r_count - CNT_W'(1)));

    // Latch the item when it is accepted.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op    <= i_op;
            r_key_a <= coord_key(i_first_end);
            r_key_b <= coord_key(i_second_end);
        end
    end

    // Memory write on a load, registered read while scanning.
    always_ff @(posedge i_clk) begin
        if (w_write) begin
            r_mem[r_count[IDX_W-1:0]] <= {w_low, w_high};
        end
        if (i_cmd.scan) begin
            r_rd_data <= r_mem[r_idx];
        end
    end

    // Next values of count, index, accumulator and full flag.
    always_comb begin
        n_count = r_count;
        n_idx   = r_idx;
        n_acc   = r_acc;
        n_full  = r_full;
        if (i_cmd.accept) begin
            n_idx  = '0;
            n_acc  = '0;
            n_full = 1'b0;
        end
        if (i_cmd.exec) begin
            case (r_op)
                OP_LOAD: begin
                    if (w_store_full) begin
                        n_full = 1'b1;
                    end else begin
                        n_count = r_count + CNT_W'(1);
                    end
                end
                OP_CLEAR: begin
                    n_count = '0;
                end
                default: begin
                    n_count = r_count;
                end
            endcase
        end
        if (i_cmd.scan) begin
            n_idx = r_idx + IDX_W'(1);
        end
        if (r_rd_vld && w_hit) begin
            n_acc = r_acc + CNT_W'(1);
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_idx    <= '0;
            r_rd_vld <= 1'b0;
            r_acc    <= '0;
            r_full   <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_idx    <= n_idx;
            r_rd_vld <= i_cmd.scan;
            r_acc    <= n_acc;
            r_full   <= n_full;
        end
    end

    assign o_covering_count = COUNT_FIELD_W'(r_acc);
    assign o_store_full     = r_full;

endmodule

### rtl/core/segment_stabbing_counter.sv
// ----------------------------------------------------------------------------
// segment_stabbing_counter: counts stored segments that contain a point
// Stores closed segments and answers, for each query point, how many stored
// segments contain it, endpoints included; one result per item.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                   Payload
//  -------   -------------------------   --------------------------------------
//  item in   start high while busy low   i_op, i_first_end, i_second_end
//  result    o_strobe for one cycle      o_covering_count, o_store_full
//
// A load, clear or unused code goes from execute straight to its result.
// A query with stored segments passes through execute, scan and drain before
// its result (with none stored it goes as a load does); the walk reads the
// single-port segment memory one entry a cycle, one entry per stored segment.
// busy falls in the cycle after the strobe. Synchronous reset empties the
// store at once; memory contents are not cleared. The receiver cannot stall.
//
module segment_stabbing_counter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [ssc_pkg::OP_W-1:0]            i_op,
    input  logic [ssc_pkg::FIELD_W-1:0]         i_first_end,
    input  logic [ssc_pkg::FIELD_W-1:0]         i_second_end,
    output logic                                o_strobe,
    output logic [ssc_pkg::COUNT_FIELD_W-1:0]   o_covering_count,
    output logic                                o_store_full
);
    import ssc_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    // Sequencing controller.
    ssc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_busy   (busy),
        .o_strobe (o_strobe)
    );

    // Store and counting datapath.
    ssc_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_op             (i_op),
        .i_first_end      (i_first_end),
        .i_second_end     (i_second_end),
        .o_status         (w_status),
        .o_covering_count (o_covering_count),
        .o_store_full     (o_store_full)
    );

endmodule

### rtl/core/ssc_checker.sv
// ----------------------------------------------------------------------------
// ssc_checker: port-level checks for the segment stabbing counter
// Watches the top level's ports and checks the item and result timing and the count of a rejected load.
// ----------------------------------------------------------------------------
module ssc_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                start,
    input logic                                busy,
    input logic                                o_strobe,
    input logic [ssc_pkg::COUNT_FIELD_W-1:0]   o_covering_count,
    input logic                                o_store_full
);
    import ssc_pkg::*;

    // An accepted item makes the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after an item was accepted");

    // A result is only shown while an item is in progress.
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (busy && $past(busy)))
        else $error("result strobe outside an item");

    // After a result the block is free again.
    a_strobe_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> (!busy && !o_strobe))
        else $error("block still busy after its result");

    // A rejected load carries no count.
    a_full_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_store_full) |-> (o_covering_count == '0))
        else $error("rejected load reported a non-zero count");

endmodule

bind segment_stabbing_counter ssc_checker u_ssc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .o_strobe         (o_strobe),
    .o_covering_count (o_covering_count),
    .o_store_full     (o_store_full)
);
